// ===== design/rwct_pkg.sv =====
package rwct_pkg;

  localparam int SCREEN_ROWS   = 512;
  localparam int HALF_ROWS     = SCREEN_ROWS / 2;
  localparam int ROW_W         = 9;
  localparam int COL_W         = 10;
  localparam int MAX_TEX_WIDTH = 256;
  localparam int WIDTH_W       = 9;
  localparam int HLOG_W        = 4;
  localparam int HLOG_MAX      = 8;
  localparam int TEX_W         = 8;
  localparam int POS_W         = 24;
  localparam int DIR_W         = 19;
  localparam int FRAC_W        = 16;
  localparam int RGB_W         = 32;
  localparam int ACC_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_W         = $clog2(SCREEN_ROWS) + FRAC_W + 1;
  localparam int CNT_W         = $clog2(DIV_W + 1);
  localparam int OFF_W         = DIV_W - 1;
  localparam int STEP_W        = HLOG_MAX + FRAC_W + 1;
  localparam int SHAMT_W       = $clog2(DIV_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING = 3'd0,
    CFG_FLOOR   = 3'd1,
    CFG_W_EAST  = 3'd2,
    CFG_W_WEST  = 3'd3,
    CFG_W_SOUTH = 3'd4,
    CFG_W_NORTH = 3'd5,
    CFG_HLOG    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_CEIL  = 2'd0,
    SRC_TEXEL = 2'd1,
    SRC_FLOOR = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } tex_e;

  typedef enum logic {
    KIND_COLUMN = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_TEX,
    ST_DIV_LH,
    ST_STEP_GO,
    ST_DIV_STEP,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic col_ld;
    logic frac_ld;
    logic div_start;
    logic div_step;
    logic tx_ld;
    logic lh_ld;
    logic step_ld;
    logic acc_ld;
    logic tick;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_blocked;
  } sts_t;

endpackage

// ===== design/rwct_div.sv =====
module rwct_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rwct_pkg::DIV_W-1:0] dividend_i,
  input  logic [rwct_pkg::DIV_W-1:0] divisor_i,
  output logic [rwct_pkg::DIV_W-1:0] quotient_o,
  output logic                       done_o
);

  logic [rwct_pkg::DIV_W-1:0] rem_q, rem_d;
  logic [rwct_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [rwct_pkg::DIV_W-1:0] dvs_q, dvs_d;
  logic [rwct_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [rwct_pkg::DIV_W:0]   shifted;
  logic                       fits;

  assign shifted = {rem_q, quo_q[rwct_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = rwct_pkg::CNT_W'(rwct_pkg::DIV_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? rwct_pkg::DIV_W'(shifted - {1'b0, dvs_q})
                    : shifted[rwct_pkg::DIV_W-1:0];
      quo_d  = {quo_q[rwct_pkg::DIV_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = cnt_q == rwct_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== design/rwct_ctrl.sv =====
module rwct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            kind_i,
  output logic            in_stall_o,
  input  rwct_pkg::sts_t  sts_i,
  output rwct_pkg::cmd_t  cmd_o
);

  rwct_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_stall_o = (state_q != rwct_pkg::ST_IDLE) || sts_i.out_blocked;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rwct_pkg::ST_IDLE: begin
        if (accept && kind_i == rwct_pkg::KIND_COLUMN) state_d = rwct_pkg::ST_PROD;
      end
      rwct_pkg::ST_PROD:     state_d = rwct_pkg::ST_TEX;
      rwct_pkg::ST_TEX:      state_d = rwct_pkg::ST_DIV_LH;
      rwct_pkg::ST_DIV_LH: begin
        if (sts_i.div_done) state_d = rwct_pkg::ST_STEP_GO;
      end
      rwct_pkg::ST_STEP_GO:  state_d = rwct_pkg::ST_DIV_STEP;
      rwct_pkg::ST_DIV_STEP: begin
        if (sts_i.div_done) state_d = rwct_pkg::ST_ACC;
      end
      rwct_pkg::ST_ACC:      state_d = rwct_pkg::ST_IDLE;
      default:               state_d = rwct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      rwct_pkg::ST_IDLE: begin
        cmd_o.col_ld = accept && kind_i == rwct_pkg::KIND_COLUMN;
        cmd_o.tick   = accept && kind_i == rwct_pkg::KIND_TICK;
      end
      rwct_pkg::ST_PROD: begin
        cmd_o.frac_ld   = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      rwct_pkg::ST_TEX:      cmd_o.tx_ld = 1'b1;
      rwct_pkg::ST_DIV_LH:   cmd_o.lh_ld = sts_i.div_done;
      rwct_pkg::ST_STEP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_step  = 1'b1;
      end
      rwct_pkg::ST_DIV_STEP: cmd_o.step_ld = sts_i.div_done;
      rwct_pkg::ST_ACC:      cmd_o.acc_ld = 1'b1;
      default:               cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/rwct_dp.sv =====
module rwct_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rwct_pkg::cmd_t                 cmd_i,
  output rwct_pkg::sts_t                 sts_o,
  input  logic                           cfg_valid_i,
  input  logic [rwct_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rwct_pkg::RGB_W-1:0]     cfg_data_i,
  input  logic [rwct_pkg::COL_W-1:0]     column_i,
  input  logic                           side_i,
  input  logic                           step_x_pos_i,
  input  logic                           step_y_pos_i,
  input  logic signed [rwct_pkg::DIR_W-1:0] dir_x_i,
  input  logic signed [rwct_pkg::DIR_W-1:0] dir_y_i,
  input  logic [rwct_pkg::POS_W-1:0]     player_x_i,
  input  logic [rwct_pkg::POS_W-1:0]     player_y_i,
  input  logic [rwct_pkg::POS_W-1:0]     wall_dist_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [rwct_pkg::COL_W-1:0]     pixel_column_o,
  output logic [rwct_pkg::ROW_W-1:0]     pixel_row_o,
  output logic [1:0]                     source_o,
  output logic [1:0]                     texture_sel_o,
  output logic [rwct_pkg::TEX_W-1:0]     texel_u_o,
  output logic [rwct_pkg::TEX_W-1:0]     texel_v_o,
  output logic [rwct_pkg::RGB_W-1:0]     flat_rgb_o,
  output logic                           last_row_o
);

  localparam int DW = rwct_pkg::DIV_W;
  localparam int OW = rwct_pkg::OFF_W;
  localparam int SW = rwct_pkg::STEP_W;
  localparam int RW = rwct_pkg::ROW_W;
  localparam int FW = rwct_pkg::FRAC_W;
  localparam int WW = rwct_pkg::WIDTH_W;
  localparam int TW = rwct_pkg::TEX_W;
  localparam int PW = rwct_pkg::POS_W + rwct_pkg::DIR_W + 1;
  localparam int XW = FW + WW;

  logic [rwct_pkg::RGB_W-1:0]   ceiling_q, floor_q;
  logic [WW-1:0]                w_east_q, w_west_q, w_south_q, w_north_q;
  logic [rwct_pkg::HLOG_W-1:0]  hlog_q;

  logic [rwct_pkg::POS_W-1:0]      dist_q;
  logic signed [rwct_pkg::DIR_W-1:0] dir_q;
  logic [FW-1:0]                   base_q;
  rwct_pkg::tex_e                  choice_q, choice_d;
  logic                            mirror_q;
  logic [rwct_pkg::COL_W-1:0]      column_q;
  logic [FW-1:0]                   frac_q;
  logic [TW-1:0]                   tex_column_q;
  logic [DW-1:0]                   lh_q;
  logic [RW-1:0]                   span_start_q, span_end_q;
  logic [OW-1:0]                   off_q;
  logic [SW-1:0]                   step_q;
  logic [rwct_pkg::ACC_W-1:0]      accum_q;
  logic [RW-1:0]                   row_q;
  logic                            active_q;

  logic                            out_valid_q;
  logic [rwct_pkg::COL_W-1:0]      pix_col_q;
  logic [RW-1:0]                   pix_row_q;
  rwct_pkg::src_e                  src_q;
  logic [1:0]                      sel_q;
  logic [TW-1:0]                   u_q, v_q;
  logic [rwct_pkg::RGB_W-1:0]      rgb_q;
  logic                            last_q;

  logic [WW-1:0]                   w_raw, w_eff;
  logic [rwct_pkg::HLOG_W-1:0]     hl_eff;
  logic [TW:0]                     hmask;
  logic signed [PW-1:0]            prod;
  logic [XW-1:0]                   tx_prod;
  logic [TW-1:0]                   tx_raw, tx_mir;
  logic [DW-1:0]                   div_dividend, div_divisor, quotient;
  logic                            div_done;
  logic [rwct_pkg::SHAMT_W-1:0]    shamt;
  logic [OW-1:0]                   lh_half;
  logic [OW+SW-1:0]                acc_prod;
  logic                            tick_go, in_ceil, in_wall, is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= '0;
      floor_q   <= '0;
      w_east_q  <= WW'(64);
      w_west_q  <= WW'(64);
      w_south_q <= WW'(64);
      w_north_q <= WW'(64);
      hlog_q    <= rwct_pkg::HLOG_W'(6);
    end else if (cfg_valid_i) begin
      case (rwct_pkg::cfg_idx_e'(cfg_index_i))
        rwct_pkg::CFG_CEILING: ceiling_q <= cfg_data_i;
        rwct_pkg::CFG_FLOOR:   floor_q   <= cfg_data_i;
        rwct_pkg::CFG_W_EAST:  w_east_q  <= cfg_data_i[WW-1:0];
        rwct_pkg::CFG_W_WEST:  w_west_q  <= cfg_data_i[WW-1:0];
        rwct_pkg::CFG_W_SOUTH: w_south_q <= cfg_data_i[WW-1:0];
        rwct_pkg::CFG_W_NORTH: w_north_q <= cfg_data_i[WW-1:0];
        rwct_pkg::CFG_HLOG:    hlog_q    <= cfg_data_i[rwct_pkg::HLOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (choice_q)
      rwct_pkg::FACE_EAST:  w_raw = w_east_q;
      rwct_pkg::FACE_WEST:  w_raw = w_west_q;
      rwct_pkg::FACE_SOUTH: w_raw = w_south_q;
      default:              w_raw = w_north_q;
    endcase
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(rwct_pkg::MAX_TEX_WIDTH)) begin
      w_eff = WW'(rwct_pkg::MAX_TEX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  assign hl_eff = (hlog_q > rwct_pkg::HLOG_W'(rwct_pkg::HLOG_MAX))
                  ? rwct_pkg::HLOG_W'(rwct_pkg::HLOG_MAX) : hlog_q;
  assign hmask  = (TW+1)'((TW+1)'(1) << hl_eff) - (TW+1)'(1);

  always_comb begin
    if (side_i) begin
      choice_d = step_y_pos_i ? rwct_pkg::FACE_SOUTH : rwct_pkg::FACE_NORTH;
    end else begin
      choice_d = step_x_pos_i ? rwct_pkg::FACE_EAST : rwct_pkg::FACE_WEST;
    end
  end

  assign prod    = $signed({1'b0, dist_q}) * dir_q;
  assign tx_prod = XW'(frac_q) * XW'(w_eff);
  assign tx_raw  = tx_prod[FW+TW-1:FW];
  assign tx_mir  = TW'(w_eff - WW'(tx_raw) - WW'(1));

  assign shamt        = rwct_pkg::SHAMT_W'(hl_eff) + rwct_pkg::SHAMT_W'(FW);
  assign div_dividend = cmd_i.div_step ? (DW'(1) << shamt)
                                       : (DW'(rwct_pkg::SCREEN_ROWS) << FW);
  assign div_divisor  = cmd_i.div_step ? lh_q
                      : ((dist_q == '0) ? DW'(1) : DW'(dist_q));

  rwct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign lh_half  = quotient[DW-1:1];
  assign acc_prod = (OW+SW)'(off_q) * (OW+SW)'(step_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_ld) begin
      dist_q   <= wall_dist_i;
      dir_q    <= side_i ? dir_x_i : dir_y_i;
      base_q   <= side_i ? player_x_i[FW-1:0] : player_y_i[FW-1:0];
      choice_q <= choice_d;
      mirror_q <= side_i ? dir_y_i[rwct_pkg::DIR_W-1]
                         : (!dir_x_i[rwct_pkg::DIR_W-1] && dir_x_i != '0);
      column_q <= column_i;
    end
    if (cmd_i.frac_ld) begin
      frac_q <= prod[2*FW-1:FW] + base_q;
    end
    if (cmd_i.tx_ld) begin
      tex_column_q <= mirror_q ? tx_mir : tx_raw;
    end
    if (cmd_i.lh_ld) begin
      lh_q <= quotient;
      if (lh_half >= OW'(rwct_pkg::HALF_ROWS)) begin
        span_start_q <= '0;
        span_end_q   <= RW'(rwct_pkg::SCREEN_ROWS - 1);
      end else begin
        span_start_q <= RW'(rwct_pkg::HALF_ROWS) - RW'(lh_half);
        span_end_q   <= RW'(rwct_pkg::HALF_ROWS) + RW'(lh_half);
      end
      off_q <= (lh_half > OW'(rwct_pkg::HALF_ROWS))
               ? lh_half - OW'(rwct_pkg::HALF_ROWS) : '0;
    end
    if (cmd_i.step_ld) begin
      step_q <= (lh_q == '0) ? '0 : quotient[SW-1:0];
    end
    if (cmd_i.acc_ld) begin
      accum_q <= acc_prod[rwct_pkg::ACC_W-1:0];
    end else if (tick_go && in_wall) begin
      accum_q <= accum_q + rwct_pkg::ACC_W'(step_q);
    end
  end

  assign tick_go = cmd_i.tick && active_q;
  assign in_ceil = row_q < span_start_q;
  assign in_wall = !in_ceil && (row_q < span_end_q);
  assign is_last = row_q == RW'(rwct_pkg::SCREEN_ROWS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.col_ld) begin
        active_q <= 1'b0;
      end else if (cmd_i.acc_ld) begin
        active_q <= 1'b1;
        row_q    <= '0;
      end else if (tick_go) begin
        active_q <= !is_last;
        row_q    <= is_last ? '0 : row_q + 1'b1;
      end
      if (tick_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      pix_col_q <= column_q;
      pix_row_q <= row_q;
      last_q    <= is_last;
      if (in_ceil) begin
        src_q <= rwct_pkg::SRC_CEIL;
        sel_q <= '0;
        u_q   <= '0;
        v_q   <= '0;
        rgb_q <= ceiling_q;
      end else if (in_wall) begin
        src_q <= rwct_pkg::SRC_TEXEL;
        sel_q <= choice_q;
        u_q   <= tex_column_q;
        v_q   <= accum_q[FW+TW-1:FW] & hmask[TW-1:0];
        rgb_q <= '0;
      end else begin
        src_q <= rwct_pkg::SRC_FLOOR;
        sel_q <= '0;
        u_q   <= '0;
        v_q   <= '0;
        rgb_q <= floor_q;
      end
    end
  end

  assign sts_o.div_done    = div_done;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pixel_column_o = pix_col_q;
  assign pixel_row_o    = pix_row_q;
  assign source_o       = src_q;
  assign texture_sel_o  = sel_q;
  assign texel_u_o      = u_q;
  assign texel_v_o      = v_q;
  assign flat_rgb_o     = rgb_q;
  assign last_row_o     = last_q;

endmodule

// ===== design/raycast_wall_column_texturer.sv =====
// Textured wall column generator for a grid raycaster. A column transaction
// (kind 0) loads one ray hit and sets up the wall span, texture choice,
// texture column and Q9.16 texture step; it returns no pixel and holds the
// input stalled while it runs a product stage, the line height division on
// the shared one-bit-per-cycle divider (26 steps, the texture column stage
// overlapping the first step), a divider launch, the texture step division
// and an accumulator multiply stage. Each row tick (kind 1) then returns
// one pixel per cycle while the output is not stalled, from row 0 down,
// ceiling, texel coordinate or floor, with the bottom row flagged; a tick
// with no column open is dropped.
// Configuration writes are taken in any cycle and must only occur while idle.
module raycast_wall_column_texturer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rwct_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rwct_pkg::RGB_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [rwct_pkg::COL_W-1:0]        column_i,
  input  logic                              side_i,
  input  logic                              step_x_pos_i,
  input  logic                              step_y_pos_i,
  input  logic signed [rwct_pkg::DIR_W-1:0] dir_x_i,
  input  logic signed [rwct_pkg::DIR_W-1:0] dir_y_i,
  input  logic [rwct_pkg::POS_W-1:0]        player_x_i,
  input  logic [rwct_pkg::POS_W-1:0]        player_y_i,
  input  logic [rwct_pkg::POS_W-1:0]        wall_dist_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rwct_pkg::COL_W-1:0]        pixel_column_o,
  output logic [rwct_pkg::ROW_W-1:0]        pixel_row_o,
  output logic [1:0]                        source_o,
  output logic [1:0]                        texture_sel_o,
  output logic [rwct_pkg::TEX_W-1:0]        texel_u_o,
  output logic [rwct_pkg::TEX_W-1:0]        texel_v_o,
  output logic [rwct_pkg::RGB_W-1:0]        flat_rgb_o,
  output logic                              last_row_o
);

  rwct_pkg::cmd_t cmd;
  rwct_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rwct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwct_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .column_i       (column_i),
    .side_i         (side_i),
    .step_x_pos_i   (step_x_pos_i),
    .step_y_pos_i   (step_y_pos_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .player_x_i     (player_x_i),
    .player_y_i     (player_y_i),
    .wall_dist_i    (wall_dist_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .source_o       (source_o),
    .texture_sel_o  (texture_sel_o),
    .texel_u_o      (texel_u_o),
    .texel_v_o      (texel_v_o),
    .flat_rgb_o     (flat_rgb_o),
    .last_row_o     (last_row_o)
  );

endmodule

// ===== design/rwct_checker.sv =====
module rwct_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              kind_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [rwct_pkg::ROW_W-1:0]        pixel_row_o,
  input logic [1:0]                        source_o,
  input logic [1:0]                        texture_sel_o,
  input logic [rwct_pkg::TEX_W-1:0]        texel_u_o,
  input logic [rwct_pkg::TEX_W-1:0]        texel_v_o,
  input logic [rwct_pkg::RGB_W-1:0]        flat_rgb_o,
  input logic                              last_row_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_row_o))
    else $error("stalled pixel dropped or changed");

  a_column_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == rwct_pkg::KIND_COLUMN |=> in_stall_o)
    else $error("column setup did not hold off input");

  a_texel_no_rgb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && source_o == rwct_pkg::SRC_TEXEL |-> flat_rgb_o == '0)
    else $error("texel pixel carries a flat colour");

  a_flat_no_texel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && source_o != rwct_pkg::SRC_TEXEL
      |-> texture_sel_o == '0 && texel_u_o == '0 && texel_v_o == '0)
    else $error("flat pixel carries texel fields");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_row_o
      |-> pixel_row_o == rwct_pkg::ROW_W'(rwct_pkg::SCREEN_ROWS - 1))
    else $error("last row flag on wrong row");

endmodule

bind raycast_wall_column_texturer rwct_checker u_rwct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .kind_i        (kind_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_row_o   (pixel_row_o),
  .source_o      (source_o),
  .texture_sel_o (texture_sel_o),
  .texel_u_o     (texel_u_o),
  .texel_v_o     (texel_v_o),
  .flat_rgb_o    (flat_rgb_o),
  .last_row_o    (last_row_o)
);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rwct_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int DIR_ONE       = 1 << FRAC_W;
  localparam int DIR_LIM       = 2 * DIR_ONE;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int RANDOM_PHASES = 4;
  localparam int RANDOM_ITEMS  = 1550;

  typedef struct {
    kind_e                    kind;
    logic [COL_W-1:0]         column;
    logic                     side;
    logic                     step_x_pos;
    logic                     step_y_pos;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic [POS_W-1:0]         player_x;
    logic [POS_W-1:0]         player_y;
    logic [POS_W-1:0]         wall_dist;
  } ray_t;

  typedef struct {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    src_e             source;
    tex_e             tex;
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
    logic [RGB_W-1:0] rgb;
    logic             last;
  } pixel_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i    = '0;
  logic [RGB_W-1:0]        cfg_data_i     = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic                    kind_i         = 1'b0;
  logic [COL_W-1:0]        column_i       = '0;
  logic                    side_i         = 1'b0;
  logic                    step_x_pos_i   = 1'b0;
  logic                    step_y_pos_i   = 1'b0;
  logic signed [DIR_W-1:0] dir_x_i        = '0;
  logic signed [DIR_W-1:0] dir_y_i        = '0;
  logic [POS_W-1:0]        player_x_i     = '0;
  logic [POS_W-1:0]        player_y_i     = '0;
  logic [POS_W-1:0]        wall_dist_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic [COL_W-1:0]        pixel_column_o;
  logic [ROW_W-1:0]        pixel_row_o;
  logic [1:0]              source_o;
  logic [1:0]              texture_sel_o;
  logic [TEX_W-1:0]        texel_u_o;
  logic [TEX_W-1:0]        texel_v_o;
  logic [RGB_W-1:0]        flat_rgb_o;
  logic                    last_row_o;

  raycast_wall_column_texturer i_dut (.*);

  // shadow registers and column state of the predictor
  logic [RGB_W-1:0]   ceil_rgb = '0;
  logic [RGB_W-1:0]   flr_rgb  = '0;
  logic [WIDTH_W-1:0] tex_width [4] = '{default: 9'd64};
  logic [HLOG_W-1:0]  hlog_reg = 4'd6;
  int                 row_ctr  = 0;
  int                 span_lo  = 0;
  int                 span_hi  = 0;
  logic [ACC_W-1:0]   v_pos    = '0;
  logic [ACC_W-1:0]   v_inc    = '0;
  tex_e               face     = FACE_EAST;
  logic [TEX_W-1:0]   u_col    = '0;
  logic [COL_W-1:0]   col_id   = '0;
  bit                 col_open = 1'b0;

  pixel_t pixels_due [$];
  int     errors     = 0;
  int     items_done = 0;
  int     stall_pct  = 0;
  int     gap_pct    = 0;
  int     stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_hlog();
    return (hlog_reg > HLOG_MAX) ? HLOG_MAX : int'(hlog_reg);
  endfunction

  function automatic void open_column(ray_t r);
    longint wall_d, prod, base, lh, st, en, stp, off;
    int w, tx;
    logic [FRAC_W-1:0] frac;
    if (r.side) begin
      face = r.step_y_pos ? FACE_SOUTH : FACE_NORTH;
    end else begin
      face = r.step_x_pos ? FACE_EAST : FACE_WEST;
    end
    w = tex_width[face];
    if (w == 0) begin
      w = 1;
    end else if (w > MAX_TEX_WIDTH) begin
      w = MAX_TEX_WIDTH;
    end
    wall_d = longint'(r.wall_dist);
    if (r.side) begin
      prod = wall_d * longint'(r.dir_x);
      base = longint'(r.player_x);
    end else begin
      prod = wall_d * longint'(r.dir_y);
      base = longint'(r.player_y);
    end
    frac = FRAC_W'((prod >>> FRAC_W) + base);
    tx = int'((longint'(frac) * w) >> FRAC_W);
    if ((!r.side && r.dir_x > 0) || (r.side && r.dir_y < 0)) begin
      tx = w - 1 - tx;
    end
    lh = (longint'(SCREEN_ROWS) << FRAC_W) / ((wall_d != 0) ? wall_d : 1);
    st = HALF_ROWS - lh / 2;
    if (st < 0) begin
      st = 0;
    end
    en = HALF_ROWS + lh / 2;
    if (en >= SCREEN_ROWS) begin
      en = SCREEN_ROWS - 1;
    end
    stp = (lh != 0) ? ((longint'(1) << (clamp_hlog() + FRAC_W)) / lh) : 0;
    off = st - HALF_ROWS + lh / 2;
    if (off < 0) begin
      off = 0;
    end
    span_lo  = int'(st);
    span_hi  = int'(en);
    v_inc    = ACC_W'(stp);
    v_pos    = ACC_W'(off * stp);
    u_col    = TEX_W'(tx);
    col_id   = r.column;
    row_ctr  = 0;
    col_open = 1'b1;
  endfunction

  // returns 1 when the transaction is not simply dropped by the block
  function automatic bit predict_item(ray_t r);
    pixel_t p;
    int hmask;
    if (r.kind == KIND_COLUMN) begin
      open_column(r);
      return 1'b1;
    end
    if (!col_open) begin
      return 1'b0;
    end
    p.column = col_id;
    p.row    = ROW_W'(row_ctr);
    p.last   = (row_ctr >= SCREEN_ROWS - 1);
    p.tex    = FACE_EAST;
    p.u      = '0;
    p.v      = '0;
    p.rgb    = '0;
    if (row_ctr < span_lo) begin
      p.source = SRC_CEIL;
      p.rgb    = ceil_rgb;
    end else if (row_ctr < span_hi) begin
      hmask    = (1 << clamp_hlog()) - 1;
      p.source = SRC_TEXEL;
      p.tex    = face;
      p.u      = u_col;
      p.v      = TEX_W'((v_pos >> FRAC_W) & hmask);
      v_pos    = v_pos + v_inc;
    end else begin
      p.source = SRC_FLOOR;
      p.rgb    = flr_rgb;
    end
    pixels_due.push_back(p);
    if (p.last) begin
      col_open = 1'b0;
      row_ctr  = 0;
    end else begin
      row_ctr++;
    end
    return 1'b1;
  endfunction

  function automatic ray_t random_ray(kind_e k);
    ray_t r;
    r.kind       = k;
    r.column     = COL_W'($urandom);
    r.side       = 1'($urandom);
    r.step_x_pos = 1'($urandom);
    r.step_y_pos = 1'($urandom);
    r.dir_x      = DIR_W'($urandom_range(0, 2 * DIR_LIM) - DIR_LIM);
    r.dir_y      = DIR_W'($urandom_range(0, 2 * DIR_LIM) - DIR_LIM);
    r.player_x   = POS_W'($urandom);
    r.player_y   = POS_W'($urandom);
    r.wall_dist  = POS_W'($urandom);
    return r;
  endfunction

  task automatic send_item(ray_t r);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= r.kind;
    column_i     <= r.column;
    side_i       <= r.side;
    step_x_pos_i <= r.step_x_pos;
    step_y_pos_i <= r.step_y_pos;
    dir_x_i      <= r.dir_x;
    dir_y_i      <= r.dir_y;
    player_x_i   <= r.player_x;
    player_y_i   <= r.player_y;
    wall_dist_i  <= r.wall_dist;
    do @(posedge clk_i); while (in_stall_o);
    items_done += predict_item(r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RGB_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CEILING: ceil_rgb = val;
      CFG_FLOOR:   flr_rgb = val;
      CFG_W_EAST:  tex_width[FACE_EAST] = WIDTH_W'(val);
      CFG_W_WEST:  tex_width[FACE_WEST] = WIDTH_W'(val);
      CFG_W_SOUTH: tex_width[FACE_SOUTH] = WIDTH_W'(val);
      CFG_W_NORTH: tex_width[FACE_NORTH] = WIDTH_W'(val);
      CFG_HLOG:    hlog_reg = HLOG_W'(val);
      default: ;
    endcase
  endtask

  task automatic wait_results();
    if (pixels_due.size() != 0) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (pixels_due.size() != 0);
    end
  endtask

  // column setup yields no pixel, so give the divider time to finish
  task automatic wait_idle();
    wait_results();
    in_valid_i <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic directed_column(logic side, logic sx, logic sy, int dx, int dy,
                                 logic [POS_W-1:0] wall_d, int ticks);
    ray_t r;
    r            = random_ray(KIND_COLUMN);
    r.side       = side;
    r.step_x_pos = sx;
    r.step_y_pos = sy;
    r.dir_x      = DIR_W'(dx);
    r.dir_y      = DIR_W'(dy);
    r.wall_dist  = wall_d;
    send_item(r);
    repeat (ticks) send_item(random_ray(KIND_TICK));
  endtask

  task automatic test_ignored_ticks();
    repeat (2) send_item(random_ray(KIND_TICK));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_CEILING, 32'hFFFF_FFFF);
    write_reg(CFG_FLOOR, 32'h0000_0000);
    write_reg(CFG_W_EAST, 32'd256);
    write_reg(CFG_W_WEST, 32'd0);
    write_reg(CFG_W_SOUTH, 32'd1);
    write_reg(CFG_W_NORTH, 32'd511);
    write_reg(CFG_HLOG, 32'd8);
    write_reg(CFG_SPARE, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_texture_faces();
    directed_column(1'b0, 1'b1, 1'b0, DIR_LIM, -DIR_LIM, '0, 2);
    directed_column(1'b0, 1'b0, 1'b1, -DIR_LIM, DIR_LIM, POS_MAX, 1);
    directed_column(1'b1, 1'b0, 1'b1, -DIR_LIM, DIR_LIM, 24'd1, 2);
    directed_column(1'b1, 1'b1, 1'b0, DIR_LIM, -DIR_LIM, 24'h01_0000, 2);
  endtask

  task automatic test_height_extremes();
    wait_idle();
    write_reg(CFG_HLOG, 32'd15);
    cfg_valid_i <= 1'b0;
    directed_column(1'b0, 1'b1, 1'b0, DIR_ONE, DIR_ONE / 2, 24'h00_8000, 3);
    wait_idle();
    write_reg(CFG_HLOG, 32'd0);
    cfg_valid_i <= 1'b0;
    directed_column(1'b1, 1'b0, 1'b1, -DIR_ONE, DIR_ONE, 24'h00_8000, 2);
  endtask

  task automatic test_drain_pause();
    directed_column(1'b0, 1'b1, 1'b1, DIR_ONE, -DIR_ONE, 24'h01_0000, 3);
    wait_results();
    repeat (3) send_item(random_ray(KIND_TICK));
  endtask

  task automatic test_random_columns();
    int limit, n, sel;
    ray_t r;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_CEILING, $urandom);
      write_reg(CFG_FLOOR, $urandom);
      for (int i = CFG_W_EAST; i <= CFG_W_NORTH; i++) begin
        write_reg(CFG_IDX_W'(i),
                  ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(0, 511));
      end
      write_reg(CFG_HLOG, (ph == 0) ? HLOG_MAX : (ph == 1) ? 0 : $urandom_range(0, 15));
      write_reg(CFG_SPARE, $urandom);
      cfg_valid_i <= 1'b0;
      limit = items_done + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_done < limit) begin
        if (ph == RANDOM_PHASES - 1) begin
          stall_pct = 0;
          gap_pct   = 0;
        end else begin
          stall_pct = 10 * $urandom_range(0, 3);
          gap_pct   = 10 * $urandom_range(0, 3);
        end
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          n = SCREEN_ROWS + $urandom_range(0, 2);
        end else if (sel < 28) begin
          n = $urandom_range(17, 300);
        end else begin
          n = $urandom_range(0, 16);
        end
        r   = random_ray(KIND_COLUMN);
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          r.wall_dist = '0;
        end else if (sel < 8) begin
          r.wall_dist = POS_MAX;
        end else if (sel < 10) begin
          r.wall_dist = 24'd1;
        end else if (n <= 16 || sel < 40) begin
          r.wall_dist = POS_W'($urandom_range(0, 24'h01_1000));
        end else if (sel < 75) begin
          r.wall_dist = POS_W'($urandom_range(24'h00_8000, 24'h10_0000));
        end
        send_item(r);
        for (int t = 0; t < n; t++) begin
          if ($urandom_range(0, 199) == 0) begin
            wait_results();
          end
          send_item(random_ray(KIND_TICK));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left  <= $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [RGB_W-1:0] want,
                                      logic [RGB_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel, column %0h row %0h", $time, pixel_column_o,
                 pixel_row_o);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_column", want.column, pixel_column_o);
        check_field("pixel_row", want.row, pixel_row_o);
        check_field("source", want.source, source_o);
        check_field("texture_sel", want.tex, texture_sel_o);
        check_field("texel_u", want.u, texel_u_o);
        check_field("texel_v", want.v, texel_v_o);
        check_field("flat_rgb", want.rgb, flat_rgb_o);
        check_field("last_row", want.last, last_row_o);
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    repeat (2) @(posedge clk_i);
    rst_ni    <= 1'b1;
    stall_pct = 20;
    gap_pct   = 20;
    test_ignored_ticks();
    test_register_extremes();
    test_texture_faces();
    test_height_extremes();
    test_drain_pause();
    test_random_columns();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pixels_due.size() != 0) begin
      $display("%0t: %0d pixels never arrived", $time, pixels_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
